FILE: hw/rtl/srle_pkg.sv
// Shared types, constants and codes of the serial RGB LED frame encoder.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package srle_pkg;

  localparam int NUM_LEDS      = 8;
  localparam int SLOTS_PER_LED = 24;
  localparam int DATA_LEN      = NUM_LEDS * SLOTS_PER_LED;

  // LED address, data-slot offset and slot position widths
  localparam int LED_AW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int D_W    = $clog2(DATA_LEN);
  localparam int X_W    = D_W - 3;
  localparam int POS_W  = $clog2(DATA_LEN + 511);

  // divide by three through a reciprocal: exact for operands below 1536
  localparam int DIV3_MUL = 683;
  localparam int DIV3_SH  = 11;
  localparam int PROD_W   = X_W + 10;

  localparam int Q_DEPTH  = 2;

  // request codes
  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_SET    = 2'd1;
  localparam logic [1:0] REQ_UPDATE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_BIT0_DUTY   = 2'd0;
  localparam logic [1:0] CFG_BIT1_DUTY   = 2'd1;
  localparam logic [1:0] CFG_LEAD_SLOTS  = 2'd2;
  localparam logic [1:0] CFG_TRAIL_SLOTS = 2'd3;

  localparam logic [7:0] RST_BIT0_DUTY   = 8'd20;
  localparam logic [7:0] RST_BIT1_DUTY   = 8'd40;
  localparam logic [7:0] RST_LEAD_SLOTS  = 8'd48;
  localparam logic [7:0] RST_TRAIL_SLOTS = 8'd48;

  typedef logic [NUM_LEDS-1:0][23:0] colour_arr_t;

  typedef struct packed {
    logic [7:0] bit0_duty;
    logic [7:0] bit1_duty;
    logic [7:0] lead_slots;
    logic [7:0] trail_slots;
  } cfg_t;

  // one classified item on its way from front to back
  typedef struct packed {
    logic           data_slot;
    logic [D_W-1:0] offset;
    logic           active;
    logic           last;
    logic           started;
    logic           busy;
    logic           dirty;
  } fb_item_t;

endpackage

FILE: hw/rtl/srle_front.sv
// Front end: accepts requests, owns the colour store and the frame state,
// and classifies each accepted request into a queue item. Depends on srle_pkg.
`timescale 1ns / 1ps

module srle_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            req_type,
  input  logic [7:0]            led_index,
  input  logic [23:0]           color_grb,
  input  srle_pkg::cfg_t        cfg,
  input  logic                  q_full,
  input  logic                  q_empty,
  output logic                  push,
  output srle_pkg::fb_item_t    item,
  output logic                  snap,
  output srle_pkg::colour_arr_t colours
);

  srle_pkg::colour_arr_t       colour_r, colour_nxt;
  logic                        dirty_r, dirty_nxt;
  logic                        busy_r, busy_nxt;
  logic [srle_pkg::POS_W-1:0]  pos_r, pos_nxt;

  logic                        idx_ok;
  logic [srle_pkg::LED_AW-1:0] idx;
  logic                        start_ok;
  logic [srle_pkg::POS_W:0]    pos_x, pos_inc, lead_x, data_end, total;
  logic                        in_data, at_end;
  logic                        accept;

  assign idx      = led_index[srle_pkg::LED_AW-1:0];
  assign idx_ok   = {1'b0, led_index} < 9'(srle_pkg::NUM_LEDS);
  assign start_ok = (req_type == srle_pkg::REQ_UPDATE) && !busy_r && dirty_r;

  // hold a frame start until the back end has drained its frame store reads
  assign in_ready = !q_full && !(start_ok && !q_empty);
  assign accept   = in_valid && in_ready;
  assign push     = accept;
  assign snap     = accept && start_ok;
  assign colours  = colour_r;

  assign pos_x    = {1'b0, pos_r};
  assign pos_inc  = pos_x + 1'b1;
  assign lead_x   = (srle_pkg::POS_W + 1)'(cfg.lead_slots);
  assign data_end = lead_x + (srle_pkg::POS_W + 1)'(srle_pkg::DATA_LEN);
  assign total    = data_end + (srle_pkg::POS_W + 1)'(cfg.trail_slots);
  assign in_data  = (pos_x >= lead_x) && (pos_x < data_end);
  assign at_end   = pos_inc >= total;

  always_comb begin
    colour_nxt = colour_r;
    dirty_nxt  = dirty_r;
    busy_nxt   = busy_r;
    pos_nxt    = pos_r;
    item       = '0;
    item.offset = srle_pkg::D_W'(pos_x - lead_x);
    unique case (req_type)
      srle_pkg::REQ_SET: begin
        if (idx_ok && (colour_r[idx] != color_grb)) begin
          colour_nxt[idx] = color_grb;
          dirty_nxt       = 1'b1;
        end
      end
      srle_pkg::REQ_UPDATE: begin
        if (start_ok) begin
          dirty_nxt    = 1'b0;
          busy_nxt     = 1'b1;
          pos_nxt      = '0;
          item.started = 1'b1;
        end
      end
      srle_pkg::REQ_TICK: begin
        if (busy_r) begin
          item.active    = 1'b1;
          item.data_slot = in_data;
          if (at_end) begin
            item.last = 1'b1;
            busy_nxt  = 1'b0;
            pos_nxt   = '0;
          end else begin
            pos_nxt = pos_inc[srle_pkg::POS_W-1:0];
          end
        end
      end
      default: begin
      end
    endcase
    item.busy  = busy_nxt;
    item.dirty = dirty_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colour_r <= '0;
      dirty_r  <= 1'b1;
      busy_r   <= 1'b0;
      pos_r    <= '0;
    end else if (accept) begin
      colour_r <= colour_nxt;
      dirty_r  <= dirty_nxt;
      busy_r   <= busy_nxt;
      pos_r    <= pos_nxt;
    end
  end

endmodule

FILE: hw/rtl/srle_queue.sv
// Two-entry queue of classified items between front and back end.
// Depends on srle_pkg.
`timescale 1ns / 1ps

module srle_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  srle_pkg::fb_item_t push_item,
  input  logic               pop,
  output logic               q_valid,
  output srle_pkg::fb_item_t head,
  output logic               q_full,
  output logic               q_empty
);

  srle_pkg::fb_item_t slot_r [srle_pkg::Q_DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign q_valid = (count_r != 2'd0);
  assign q_empty = (count_r == 2'd0);
  assign q_full  = (count_r == 2'(srle_pkg::Q_DEPTH));
  assign head    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: hw/rtl/srle_back.sv
// Back end: holds the frame store, turns data slots into bit duties and
// drives the registered result beat. Depends on srle_pkg.
`timescale 1ns / 1ps

module srle_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  snap,
  input  srle_pkg::colour_arr_t colours,
  input  srle_pkg::cfg_t        cfg,
  input  logic                  q_valid,
  input  srle_pkg::fb_item_t    head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            duty,
  output logic                  slot_active,
  output logic                  frame_last,
  output logic                  update_started,
  output logic                  busy_res,
  output logic                  dirty
);

  srle_pkg::colour_arr_t        frame_r;
  logic                         valid_r, valid_nxt;
  logic [7:0]                   duty_r;
  logic                         active_r, last_r, started_r, busy_r, dirty_r;

  logic [srle_pkg::X_W-1:0]     grp;
  logic [srle_pkg::PROD_W-1:0]  prod;
  logic [srle_pkg::LED_AW-1:0]  led;
  logic [srle_pkg::D_W-1:0]     led_x, led_base;
  logic [4:0]                   bitn;
  logic [23:0]                  colour;
  logic                         data_bit;
  logic [7:0]                   duty_nxt;

  // offset / 24 = (offset / 8) / 3, remainder from the quotient
  assign grp      = head.offset[srle_pkg::D_W-1:3];
  assign prod     = srle_pkg::PROD_W'(grp) * srle_pkg::PROD_W'(srle_pkg::DIV3_MUL);
  assign led      = prod[srle_pkg::DIV3_SH +: srle_pkg::LED_AW];
  assign led_x    = srle_pkg::D_W'(led);
  assign led_base = (led_x << 4) + (led_x << 3);
  assign bitn     = 5'(head.offset - led_base);
  assign colour   = frame_r[led];
  assign data_bit = colour[5'd23 - bitn];

  always_comb begin
    duty_nxt = 8'd0;
    if (head.data_slot) begin
      duty_nxt = data_bit ? cfg.bit1_duty : cfg.bit0_duty;
    end
  end

  assign pop = q_valid && (!valid_r || out_ready);

  always_comb begin
    valid_nxt = valid_r;
    if (pop) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (snap) begin
      frame_r <= colours;
    end
    if (pop) begin
      duty_r    <= duty_nxt;
      active_r  <= head.active;
      last_r    <= head.last;
      started_r <= head.started;
      busy_r    <= head.busy;
      dirty_r   <= head.dirty;
    end
  end

  assign out_valid      = valid_r;
  assign duty           = duty_r;
  assign slot_active    = active_r;
  assign frame_last     = last_r;
  assign update_started = started_r;
  assign busy_res       = busy_r;
  assign dirty          = dirty_r;

endmodule

FILE: hw/rtl/serial_rgb_led_frame_encoder_unit.sv
// Top level of the serial RGB LED frame encoder: configuration registers,
// front end, item queue and back end. Depends on srle_pkg, srle_front,
// srle_queue and srle_back.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   in_     | slave     | in_tvalid/in_tready  | tuser req_type, tdata index+GRB
//   out_    | master    | out_tvalid/out_tready| tuser slot_active, tlast, tdata
//   cfg_    | slave     | cfg_valid/cfg_ready  | cfg_addr index, cfg_data value
//
// One item per cycle sustained while out_tready stays high; a result passes
// through the queue slot register, then the back end output register.
// An update that starts a frame waits until the queue has drained, since
// the frame store is read by queued data slots.
// Synchronous active-low reset clears the colour store, sets the dirty flag
// and restores the register defaults. cfg_ready is always high.
`timescale 1ns / 1ps

module serial_rgb_led_frame_encoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  input  logic [31:0] in_tdata,   // [7:0] led_index, [31:8] color_grb
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic        out_tlast,  // frame_last
  output logic        out_tuser,  // [0] slot_active
  output logic [15:0] out_tdata,  // [7:0] duty, [8] update_started, [9] busy_res,
                                  // [10] dirty, [15:11] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_data
);

  srle_pkg::cfg_t        cfg_r, cfg_nxt;
  srle_pkg::fb_item_t    item, head;
  srle_pkg::colour_arr_t colours;
  logic                  push, pop, snap;
  logic                  q_valid, q_full, q_empty;
  logic [7:0]            duty;
  logic                  update_started, busy_res, dirty;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_addr)
        srle_pkg::CFG_BIT0_DUTY:   cfg_nxt.bit0_duty   = cfg_data;
        srle_pkg::CFG_BIT1_DUTY:   cfg_nxt.bit1_duty   = cfg_data;
        srle_pkg::CFG_LEAD_SLOTS:  cfg_nxt.lead_slots  = cfg_data;
        srle_pkg::CFG_TRAIL_SLOTS: cfg_nxt.trail_slots = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bit0_duty   <= srle_pkg::RST_BIT0_DUTY;
      cfg_r.bit1_duty   <= srle_pkg::RST_BIT1_DUTY;
      cfg_r.lead_slots  <= srle_pkg::RST_LEAD_SLOTS;
      cfg_r.trail_slots <= srle_pkg::RST_TRAIL_SLOTS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  srle_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .req_type  (in_tuser),
    .led_index (in_tdata[7:0]),
    .color_grb (in_tdata[31:8]),
    .cfg       (cfg_r),
    .q_full    (q_full),
    .q_empty   (q_empty),
    .push      (push),
    .item      (item),
    .snap      (snap),
    .colours   (colours)
  );

  srle_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (item),
    .pop       (pop),
    .q_valid   (q_valid),
    .head      (head),
    .q_full    (q_full),
    .q_empty   (q_empty)
  );

  srle_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .snap           (snap),
    .colours        (colours),
    .cfg            (cfg_r),
    .q_valid        (q_valid),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .duty           (duty),
    .slot_active    (out_tuser),
    .frame_last     (out_tlast),
    .update_started (update_started),
    .busy_res       (busy_res),
    .dirty          (dirty)
  );

  assign out_tdata = {5'd0, dirty, busy_res, update_started, duty};

  // the final slot of a frame is a slot and leaves the block idle
  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser && !busy_res)
    else $error("final slot without slot flag or with busy still set");

  // a started frame is busy and clean
  a_start_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && update_started |-> busy_res && !dirty && !out_tuser)
    else $error("frame start with inconsistent flags");

  // no item enters while the queue is full
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !in_tready)
    else $error("input ready while queue is full");

  // a frame start only snapshots into an empty queue
  a_snap_drained: assert property (@(posedge clk) disable iff (!rst_n)
    snap |-> q_empty && !q_valid)
    else $error("frame store snapshot with slots still queued");

endmodule

FILE: tb/testbench.sv
// Self-checking bench for the serial RGB LED frame encoder: directed table, then random
// set/update/tick sequences over several register settings, checked against a local model.
// Depends on srle_pkg and serial_rgb_led_frame_encoder_unit.
`timescale 1ns / 1ps

module testbench;
  import srle_pkg::*;

  localparam logic [1:0] REQ_NOP = 2'd3;
  localparam int MAX_SHOWN   = 10;
  localparam int HOLD_CYCLES = 400;
  localparam int DIR_COUNT   = 15;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 80;
  localparam int LIMIT_NS    = 2_000_000;

  typedef struct packed {
    logic [7:0] duty;
    logic       slot_active;
    logic       frame_last;
    logic       update_started;
    logic       busy;
    logic       dirty;
  } slot_res_t;

  typedef struct packed {
    logic [1:0]  req;
    logic [7:0]  idx;
    logic [23:0] col;
    logic        typed;
    slot_res_t   res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser = '0;    // [1:0] req_type
  logic [31:0] in_tdata = '0;    // [7:0] led_index, [31:8] color_grb
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        out_tlast;        // frame_last
  logic        out_tuser;        // [0] slot_active
  logic [15:0] out_tdata;        // [7:0] duty, [8] update_started, [9] busy_res, [10] dirty
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_addr = '0;
  logic [7:0]  cfg_data = '0;

  serial_rgb_led_frame_encoder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // model state
  logic [23:0] led_colours  [NUM_LEDS];
  logic [23:0] snap_colours [NUM_LEDS];
  logic        dirty_flag;
  logic        frame_busy;
  logic [15:0] slot_pos;
  logic [7:0]  cfg_bit0, cfg_bit1, cfg_lead, cfg_trail;

  slot_res_t   slot_q [$];
  int          errors = 0;
  logic        cur_typed = 1'b0;
  slot_res_t   cur_typed_res = '0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int          burst_left = 0;

  function automatic void reset_model();
    for (int i = 0; i < NUM_LEDS; i++) begin
      led_colours[i]  = '0;
      snap_colours[i] = '0;
    end
    dirty_flag = 1'b1;
    frame_busy = 1'b0;
    slot_pos   = '0;
    cfg_bit0   = RST_BIT0_DUTY;
    cfg_bit1   = RST_BIT1_DUTY;
    cfg_lead   = RST_LEAD_SLOTS;
    cfg_trail  = RST_TRAIL_SLOTS;
  endfunction

  function automatic slot_res_t predict_slot(input logic [1:0] req, input logic [7:0] idx,
                                             input logic [23:0] col);
    slot_res_t r;
    int total;
    int p;
    int d;
    r = '0;
    total = int'(cfg_lead) + DATA_LEN + int'(cfg_trail);
    p = int'(slot_pos);
    if (req == REQ_SET) begin
      if (idx < NUM_LEDS && led_colours[idx] != col) begin
        led_colours[idx] = col;
        dirty_flag = 1'b1;
      end
    end else if (req == REQ_UPDATE) begin
      if (!frame_busy && dirty_flag) begin
        dirty_flag = 1'b0;
        for (int i = 0; i < NUM_LEDS; i++) snap_colours[i] = led_colours[i];
        frame_busy = 1'b1;
        slot_pos = '0;
        r.update_started = 1'b1;
      end
    end else if (req == REQ_TICK && frame_busy) begin
      r.slot_active = 1'b1;
      if (p >= int'(cfg_lead) && p < int'(cfg_lead) + DATA_LEN) begin
        d = p - int'(cfg_lead);
        // green, red, blue; MSB first
        r.duty = snap_colours[d / SLOTS_PER_LED][23 - (d % SLOTS_PER_LED)] ? cfg_bit1 : cfg_bit0;
      end
      if (p + 1 >= total) begin
        r.frame_last = 1'b1;
        frame_busy = 1'b0;
        slot_pos = '0;
      end else begin
        slot_pos = 16'(p + 1);
      end
    end
    r.busy  = frame_busy;
    r.dirty = dirty_flag;
    return r;
  endfunction

  function automatic dir_row_t dir_row(input int i);
    dir_row_t r;
    r = '0;
    case (i)
      0:  r = {REQ_TICK,   8'd0,   24'h000000, 1'b1, 8'd0, 5'b00001};
      1:  r = {REQ_NOP,    8'hFF,  24'hFFFFFF, 1'b1, 8'd0, 5'b00001};
      2:  r = {REQ_SET,    8'd0,   24'hFFFFFF, 1'b1, 8'd0, 5'b00001};
      3:  r = {REQ_SET,    8'd7,   24'h000001, 1'b1, 8'd0, 5'b00001};
      4:  r = {REQ_SET,    8'd8,   24'h123456, 1'b1, 8'd0, 5'b00001};
      5:  r = {REQ_SET,    8'hFF,  24'hFFFFFF, 1'b1, 8'd0, 5'b00001};
      6:  r = {REQ_SET,    8'd3,   24'hA5A5A5, 1'b0, 8'd0, 5'b00000};
      7:  r = {REQ_UPDATE, 8'd0,   24'h000000, 1'b1, 8'd0, 5'b00110};
      8:  r = {REQ_UPDATE, 8'd0,   24'h000000, 1'b1, 8'd0, 5'b00010};
      9:  r = {REQ_TICK,   8'd0,   24'h000000, 1'b1, 8'd0, 5'b10010};
      10: r = {REQ_SET,    8'd0,   24'hFFFFFF, 1'b1, 8'd0, 5'b00010};
      11: r = {REQ_SET,    8'd1,   24'h800000, 1'b1, 8'd0, 5'b00011};
      12: r = {REQ_UPDATE, 8'd0,   24'h000000, 1'b1, 8'd0, 5'b00011};
      13: r = {REQ_NOP,    8'd0,   24'h000000, 1'b1, 8'd0, 5'b00011};
      default: r = {REQ_TICK, 8'd0, 24'h000000, 1'b0, 8'd0, 5'b00000};
    endcase
    return r;
  endfunction

  // predict on every accepted input beat, check every accepted output beat
  always @(posedge clk) begin : monitor
    slot_res_t got;
    slot_res_t want;
    slot_res_t pred;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          CFG_BIT0_DUTY:   cfg_bit0  = cfg_data;
          CFG_BIT1_DUTY:   cfg_bit1  = cfg_data;
          CFG_LEAD_SLOTS:  cfg_lead  = cfg_data;
          CFG_TRAIL_SLOTS: cfg_trail = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        pred = predict_slot(in_tuser, in_tdata[7:0], in_tdata[31:8]);
        slot_q.push_back(cur_typed ? cur_typed_res : pred);
      end
      if (out_tvalid && out_tready) begin
        got = {out_tdata[7:0], out_tuser, out_tlast, out_tdata[8], out_tdata[9], out_tdata[10]};
        if (slot_q.size() == 0) begin
          if (errors < MAX_SHOWN)
            $display("unexpected output beat: duty %0d active %b last %b", got.duty,
                     got.slot_active, got.frame_last);
          errors++;
        end else begin
          want = slot_q.pop_front();
          if (got != want || out_tdata[15:11] != '0) begin
            if (errors < MAX_SHOWN) begin
              $write("mismatch exp/act: duty %0d/%0d active %b/%b last %b/%b ",
                     want.duty, got.duty, want.slot_active, got.slot_active,
                     want.frame_last, got.frame_last);
              $display("started %b/%b busy %b/%b dirty %b/%b pad %h",
                       want.update_started, got.update_started, want.busy, got.busy,
                       want.dirty, got.dirty, out_tdata[15:11]);
            end
            errors++;
          end
        end
      end
    end
  end

  task automatic send_item(input logic [1:0] req, input logic [7:0] idx, input logic [23:0] col,
                           input logic typed, input slot_res_t tres);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 24);
    end
    burst_left--;
    in_tvalid     <= 1'b1;
    in_tuser      <= req;
    in_tdata      <= {col, idx};
    cur_typed     <= typed;
    cur_typed_res <= tres;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // stop offering and wait until every result is back
  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (slot_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(input logic [7:0] b0, input logic [7:0] b1,
                            input logic [7:0] lead, input logic [7:0] trail);
    logic [7:0] vals  [4];
    logic [1:0] addrs [4];
    vals  = '{b0, b1, lead, trail};
    addrs = '{CFG_BIT0_DUTY, CFG_BIT1_DUTY, CFG_LEAD_SLOTS, CFG_TRAIL_SLOTS};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_addr  <= addrs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic pick_set(output logic [7:0] idx, output logic [23:0] col);
    int r;
    r = $urandom_range(0, 7);
    idx = (r == 0) ? 8'($urandom_range(NUM_LEDS, 255)) : 8'($urandom_range(0, NUM_LEDS - 1));
    r = $urandom_range(0, 9);
    if (r < 2 && idx < NUM_LEDS) col = led_colours[idx];
    else if (r == 2)             col = 24'h000000;
    else if (r == 3)             col = 24'hFFFFFF;
    else                         col = 24'($urandom());
  endtask

  task automatic run_phase(input int target);
    int sent;
    int k;
    int n;
    logic [7:0]  idx;
    logic [23:0] col;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise: any request type with random fields
        repeat ($urandom_range(1, 4)) begin
          k = $urandom_range(0, 3);
          send_item(k[1:0], 8'($urandom()), 24'($urandom()), 1'b0, '0);
          if (k[1:0] != REQ_NOP) sent++;
        end
      end else begin
        repeat ($urandom_range(0, 3)) begin
          pick_set(idx, col);
          send_item(REQ_SET, idx, col, 1'b0, '0);
          sent++;
        end
        send_item(REQ_UPDATE, 8'($urandom()), 24'($urandom()), 1'b0, '0);
        sent++;
        n = $urandom_range(1, 200);
        for (int j = 0; j < n && sent < target; j++) begin
          if ($urandom_range(0, 29) == 0) begin
            // poke the frame in flight
            k = $urandom_range(1, 3);
            if (k[1:0] == REQ_SET) pick_set(idx, col);
            else begin
              idx = 8'($urandom());
              col = 24'($urandom());
            end
            send_item(k[1:0], idx, col, 1'b0, '0);
            if (k[1:0] != REQ_NOP) sent++;
          end
          send_item(REQ_TICK, 8'($urandom()), 24'($urandom()), 1'b0, '0);
          sent++;
        end
      end
    end
  endtask

  // receiver: segments of steady, random or mostly stalled ready, plus one long hold
  initial begin : receiver
    int seg;
    int mode;
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      seg  = $urandom_range(1, 40);
      mode = $urandom_range(0, 3);
      repeat (seg) begin
        case (mode)
          0, 1:    out_tready <= 1'b1;
          2:       out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    dir_row_t row;
    reset_model();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < DIR_COUNT; i++) begin
      row = dir_row(i);
      send_item(row.req, row.idx, row.col, row.typed, row.res);
    end
    drain();
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: write_regs(8'd0, 8'd255, 8'd0, 8'd0);
        1: write_regs(8'd255, 8'd0, 8'd255, 8'd255);
        5: write_regs(RST_BIT0_DUTY, RST_BIT1_DUTY, RST_LEAD_SLOTS, RST_TRAIL_SLOTS);
        default: write_regs(8'($urandom()), 8'($urandom()), 8'($urandom_range(0, 8)),
                            8'($urandom_range(0, 8)));
      endcase
      if (ph == 2) hold_req = 1'b1;
      run_phase(PHASE_ITEMS);
      drain();
    end
    repeat (20) @(posedge clk);
    if (errors == 0 && slot_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
